>>> sv/block_variance_sse_defines.svh
// ----------------------------------------------------------------------------
// block_variance_sse_defines: assertion macros
// shared property shapes for the checker of the variance block
// ----------------------------------------------------------------------------
`ifndef BLOCK_VARIANCE_SSE_DEFINES_SVH
`define BLOCK_VARIANCE_SSE_DEFINES_SVH

// same-cycle implication, off while reset is low
`define BVS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("block_variance_sse assertion failed");

// next-cycle implication, off while reset is low
`define BVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("block_variance_sse assertion failed");

// next-cycle implication that is also checked across reset
`define BVS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("block_variance_sse assertion failed");

`endif

>>> sv/bvs_pkg.sv
// ----------------------------------------------------------------------------
// bvs_pkg: shared types and constants
// register map, config struct and size clamp for the variance block
// ----------------------------------------------------------------------------
package bvs_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int DIM_W      = 3;
    localparam int OUT_W      = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;
    localparam logic [DIM_W-1:0] DIM_MIN   = 3'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH_LOG2  = 2'd0,
        CFG_HEIGHT_LOG2 = 2'd1,
        CFG_MSE_MODE    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_W-1:0] width_log2;
        logic [DIM_W-1:0] height_log2;
        logic             mse_mode;
    } t_cfg_regs;

    // out-of-range sizes fold to the nearest legal one
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> sv/block_variance_sse.sv
// ----------------------------------------------------------------------------
// block_variance_sse: streaming block variance and sse
// one source/reference pixel pair per word, one result word per block
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------
//  pixels   | in        | i_valid / o_ready        | i_src_pixel, i_ref_pixel
//  result   | out       | o_valid / i_ready        | o_variance, o_sse_out
//  config   | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
//  one pixel word per cycle unless a final pixel waits on a stalled result;
//  every stage holds a register, the only loop is the sum/sse/count update
//  in the accumulator; block totals then pass the product and output registers
//  reset: sizes 16x16, variance mode, sums and count cleared, pipeline empty
//  a stalled result holds the finish stage and the block totals; o_ready drops
//  only once the pipeline is full; non-final pixels still drain into the sums
// ----------------------------------------------------------------------------
module block_variance_sse #(
    parameter int MAX_DIM_LOG2 = 6,
    parameter int PIXEL_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel words
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [PIXEL_BITS-1:0]             i_src_pixel,
    input  logic [PIXEL_BITS-1:0]             i_ref_pixel,
    // result words
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [bvs_pkg::OUT_W-1:0]         o_variance,
    output logic [bvs_pkg::OUT_W-1:0]         o_sse_out,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bvs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bvs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int DIFF_W  = PIXEL_BITS + 1;
    localparam int SQ_W    = 2 * PIXEL_BITS;
    localparam int CNT_W   = 2 * MAX_DIM_LOG2;
    localparam int SUM_W   = PIXEL_BITS + 1 + CNT_W;
    localparam int SHIFT_W = $clog2(CNT_W + 1);

    // configuration registers
    bvs_pkg::t_cfg_regs r_cfg;

    // input register
    logic                   r_a_valid;
    logic [PIXEL_BITS-1:0]  r_a_src;
    logic [PIXEL_BITS-1:0]  r_a_ref;

    // stage links
    logic                          b_in_ready;
    logic                          b_valid;
    logic signed [DIFF_W-1:0]      b_diff;
    logic [SQ_W-1:0]               b_sq;
    logic                          acc_in_ready;
    logic                          c_valid;
    logic signed [SUM_W-1:0]       c_sum;
    logic [bvs_pkg::OUT_W-1:0]     c_sse;
    logic [SHIFT_W-1:0]            c_shift;
    logic                          c_mse;
    logic                          fin_in_ready;

    // writes are always taken; an unknown index is dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_log2  <= bvs_pkg::DIM_RESET;
            r_cfg.height_log2 <= bvs_pkg::DIM_RESET;
            r_cfg.mse_mode    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (bvs_pkg::t_cfg_idx'(i_cfg_index))
                bvs_pkg::CFG_WIDTH_LOG2: begin
                    r_cfg.width_log2 <= i_cfg_data[bvs_pkg::DIM_W-1:0];
                end
                bvs_pkg::CFG_HEIGHT_LOG2: begin
                    r_cfg.height_log2 <= i_cfg_data[bvs_pkg::DIM_W-1:0];
                end
                bvs_pkg::CFG_MSE_MODE: begin
                    r_cfg.mse_mode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // pixel input register
    assign o_ready = !r_a_valid || b_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_a_src <= i_src_pixel;
            r_a_ref <= i_ref_pixel;
        end
    end

    bvs_diff_sq #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_diff_sq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_a_valid),
        .o_in_ready  (b_in_ready),
        .i_src       (r_a_src),
        .i_ref       (r_a_ref),
        .o_out_valid (b_valid),
        .i_out_ready (acc_in_ready),
        .o_diff      (b_diff),
        .o_sq        (b_sq)
    );

    bvs_accum #(
        .PIXEL_BITS   (PIXEL_BITS),
        .MAX_DIM_LOG2 (MAX_DIM_LOG2)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (b_valid),
        .o_in_ready  (acc_in_ready),
        .i_diff      (b_diff),
        .i_sq        (b_sq),
        .o_out_valid (c_valid),
        .i_out_ready (fin_in_ready),
        .o_sum       (c_sum),
        .o_sse       (c_sse),
        .o_shift     (c_shift),
        .o_mse       (c_mse)
    );

    bvs_finish #(
        .SUM_W   (SUM_W),
        .SHIFT_W (SHIFT_W)
    ) u_finish (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (c_valid),
        .o_in_ready (fin_in_ready),
        .i_sum      (c_sum),
        .i_sse      (c_sse),
        .i_shift    (c_shift),
        .i_mse      (c_mse),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_variance (o_variance),
        .o_sse_out  (o_sse_out)
    );

endmodule

>>> sv/bvs_diff_sq.sv
// ----------------------------------------------------------------------------
// bvs_diff_sq: difference and square stage
// registers the signed difference and its exact square for one pixel pair
// ----------------------------------------------------------------------------
module bvs_diff_sq #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [PIXEL_BITS-1:0]         i_src,
    input  logic [PIXEL_BITS-1:0]         i_ref,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [PIXEL_BITS:0]    o_diff,
    output logic [2*PIXEL_BITS-1:0]       o_sq
);

    logic                        r_valid;
    logic signed [PIXEL_BITS:0]  r_diff;
    logic [2*PIXEL_BITS-1:0]     r_sq;
    logic signed [PIXEL_BITS:0]  n_diff;
    logic [PIXEL_BITS-1:0]       n_mag;
    logic [2*PIXEL_BITS-1:0]     n_sq;

    assign o_in_ready = !r_valid || i_out_ready;

    always_comb begin
        n_diff = $signed({1'b0, i_src}) - $signed({1'b0, i_ref});
        // magnitude from two parallel subtracts
        n_mag  = (i_src > i_ref) ? (i_src - i_ref) : (i_ref - i_src);
        n_sq   = n_mag * n_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_diff <= n_diff;
            r_sq   <= n_sq;
        end
    end

    assign o_out_valid = r_valid;
    assign o_diff      = r_diff;
    assign o_sq        = r_sq;

endmodule

>>> sv/bvs_accum.sv
// ----------------------------------------------------------------------------
// bvs_accum: block accumulator
// running sums and pixel count; hands the block totals on at the last pixel
// ----------------------------------------------------------------------------
module bvs_accum #(
    parameter int PIXEL_BITS   = 16,
    parameter int MAX_DIM_LOG2 = 6,
    localparam int DIFF_W  = PIXEL_BITS + 1,
    localparam int SQ_W    = 2 * PIXEL_BITS,
    localparam int CNT_W   = 2 * MAX_DIM_LOG2,
    localparam int SUM_W   = PIXEL_BITS + 1 + CNT_W,
    localparam int SHIFT_W = $clog2(CNT_W + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bvs_pkg::t_cfg_regs           i_cfg,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DIFF_W-1:0]     i_diff,
    input  logic [SQ_W-1:0]              i_sq,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [SUM_W-1:0]      o_sum,
    output logic [bvs_pkg::OUT_W-1:0]    o_sse,
    output logic [SHIFT_W-1:0]           o_shift,
    output logic                         o_mse
);

    logic signed [SUM_W-1:0]        r_sum;
    logic [bvs_pkg::OUT_W-1:0]      r_sse;
    logic [CNT_W-1:0]               r_count;
    logic                           r_c_valid;
    logic signed [SUM_W-1:0]        r_c_sum;
    logic [bvs_pkg::OUT_W-1:0]      r_c_sse;
    logic [SHIFT_W-1:0]             r_c_shift;
    logic                           r_c_mse;

    logic signed [SUM_W-1:0]        n_sum;
    logic [bvs_pkg::OUT_W-1:0]      n_sse;
    logic [CNT_W:0]                 n_count;
    logic [CNT_W:0]                 total;
    logic [SHIFT_W-1:0]             shift;
    logic                           last;
    logic                           take;

    always_comb begin
        shift = SHIFT_W'(bvs_pkg::clamp_dim(i_cfg.width_log2,
                                            bvs_pkg::DIM_W'(MAX_DIM_LOG2)))
              + SHIFT_W'(bvs_pkg::clamp_dim(i_cfg.height_log2,
                                            bvs_pkg::DIM_W'(MAX_DIM_LOG2)));
        total   = (CNT_W + 1)'(1) << shift;
        n_count = {1'b0, r_count} + (CNT_W + 1)'(1);
        // a shrunk block size ends the block as soon as the count reaches or passes it
        last    = n_count >= total;
        n_sum   = r_sum + SUM_W'(i_diff);
        n_sse   = r_sse + bvs_pkg::OUT_W'(i_sq);
    end

    assign o_in_ready = !last || !r_c_valid || i_out_ready;
    assign take       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_sse     <= '0;
            r_count   <= '0;
            r_c_valid <= 1'b0;
        end else begin
            if (take) begin
                if (last) begin
                    r_sum   <= '0;
                    r_sse   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_sse   <= n_sse;
                    r_count <= n_count[CNT_W-1:0];
                end
            end
            if (!r_c_valid || i_out_ready) begin
                r_c_valid <= take && last;
            end
        end
        if (take && last && (!r_c_valid || i_out_ready)) begin
            r_c_sum   <= n_sum;
            r_c_sse   <= n_sse;
            r_c_shift <= shift;
            r_c_mse   <= i_cfg.mse_mode;
        end
    end

    assign o_out_valid = r_c_valid;
    assign o_sum       = r_c_sum;
    assign o_sse       = r_c_sse;
    assign o_shift     = r_c_shift;
    assign o_mse       = r_c_mse;

endmodule

>>> sv/bvs_finish.sv
// ----------------------------------------------------------------------------
// bvs_finish: variance finish
// squares the block sum, scales it down and forms the result word
// ----------------------------------------------------------------------------
module bvs_finish #(
    parameter int SUM_W   = 29,
    parameter int SHIFT_W = 4,
    localparam int PROD_W = 2 * SUM_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [SUM_W-1:0]      i_sum,
    input  logic [bvs_pkg::OUT_W-1:0]    i_sse,
    input  logic [SHIFT_W-1:0]           i_shift,
    input  logic                         i_mse,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bvs_pkg::OUT_W-1:0]    o_variance,
    output logic [bvs_pkg::OUT_W-1:0]    o_sse_out
);

    logic                          r_d_valid;
    logic [PROD_W-1:0]             r_d_prod;
    logic [bvs_pkg::OUT_W-1:0]     r_d_sse;
    logic [SHIFT_W-1:0]            r_d_shift;
    logic                          r_d_mse;
    logic                          r_valid;
    logic [bvs_pkg::OUT_W-1:0]     r_variance;
    logic [bvs_pkg::OUT_W-1:0]     r_sse_out;

    logic signed [PROD_W-1:0]      n_prod;
    logic [PROD_W-1:0]             scaled;
    logic [bvs_pkg::OUT_W-1:0]     n_variance;
    logic                          out_free;

    // signed square equals the square of the magnitude
    assign n_prod = i_sum * i_sum;

    always_comb begin
        scaled     = r_d_prod >> r_d_shift;
        n_variance = r_d_mse ? r_d_sse : (r_d_sse - bvs_pkg::OUT_W'(scaled));
    end

    assign out_free   = !r_valid || i_ready;
    assign o_in_ready = !r_d_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_d_valid <= i_in_valid;
            end
            if (out_free) begin
                r_valid <= r_d_valid;
            end
        end
        if (o_in_ready && i_in_valid) begin
            r_d_prod  <= PROD_W'(n_prod);
            r_d_sse   <= i_sse;
            r_d_shift <= i_shift;
            r_d_mse   <= i_mse;
        end
        if (out_free && r_d_valid) begin
            r_variance <= n_variance;
            r_sse_out  <= r_d_sse;
        end
    end

    assign o_valid    = r_valid;
    assign o_variance = r_variance;
    assign o_sse_out  = r_sse_out;

endmodule

>>> sv/bvs_checker.sv
// ----------------------------------------------------------------------------
// bvs_checker: port-level checks
// watches the top-level handshakes of the variance block over time
// ----------------------------------------------------------------------------
`include "block_variance_sse_defines.svh"

module bvs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [bvs_pkg::OUT_W-1:0]       o_sse_out
);

    // a stalled result stays up with its word unchanged
    `BVS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `BVS_ASSERT_NEXT(a_out_data_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_sse_out))

    // a drained output side never blocks pixel intake
    `BVS_ASSERT_IMPLY(a_ready_follows, i_clk, i_rst_n, i_ready || !o_valid, o_ready)

    // reset empties the pipeline
    `BVS_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_valid)

endmodule

bind block_variance_sse bvs_checker u_bvs_checker (.*);
